[hw/rtl/kpu_pkg.sv]
// Shared types, constants and the factorial table for the permutation unranker.
`timescale 1ns / 1ps

package kpu_pkg;

  // Largest set size accepted; the 29-bit rank holds at most 12!, so it is capped at twelve
  localparam int MaxSize = 12;
  localparam int HwLimit = 12;
  localparam int SizeCap = (MaxSize < HwLimit) ? MaxSize : HwLimit;

  localparam int SizeW = 4;
  localparam int RankW = 29;
  localparam int ElemW = 4;

  // Input transaction
  typedef struct packed {
    logic [SizeW-1:0] set_size;
    logic [RankW-1:0] rank;
  } kpu_in_t;

  // Result transaction
  typedef struct packed {
    logic [ElemW-1:0] element;
    logic             last;
    logic             error;
  } kpu_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the input transaction
    logic init;      // load rank-1, size and the unused list
    logic sub;       // take one factorial off the remaining rank
    logic emit;      // send the selected element and drop it from the list
    logic emit_err;  // send the single error result
  } kpu_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bad_input;  // size or rank out of range
    logic rank_ge;    // remaining rank still at or above the factorial
    logic last_pos;   // one place left to fill
    logic out_free;   // output register can take a result
  } kpu_sts_t;

  // n! for n = 0..12; codes above twelve return zero
  function automatic logic [RankW-1:0] kpu_fact(input logic [SizeW-1:0] n);
    logic [RankW-1:0] f;
    case (n)
      4'd0:    f = 29'd1;
      4'd1:    f = 29'd1;
      4'd2:    f = 29'd2;
      4'd3:    f = 29'd6;
      4'd4:    f = 29'd24;
      4'd5:    f = 29'd120;
      4'd6:    f = 29'd720;
      4'd7:    f = 29'd5040;
      4'd8:    f = 29'd40320;
      4'd9:    f = 29'd362880;
      4'd10:   f = 29'd3628800;
      4'd11:   f = 29'd39916800;
      4'd12:   f = 29'd479001600;
      default: f = 29'd0;
    endcase
    return f;
  endfunction

endpackage

[hw/rtl/kth_permutation_unrank.sv]
// Top level: k-th lexicographic permutation of 1..n, one element per result transaction.
// Each accepted transaction is range-checked; then, for every place, the repeated-subtraction
//   divider takes off the factorial once per unit of the digit (0..n-1), one digit per pass,
//   before the element is emitted. A new transaction is taken only after the last element.
// An out-of-range transaction yields its single error result once the range check fails.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any pending result.
`timescale 1ns / 1ps

module kth_permutation_unrank (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kpu_pkg::kpu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output kpu_pkg::kpu_out_t out_data
);

  kpu_pkg::kpu_cmd_t cmd;
  kpu_pkg::kpu_sts_t sts;

  kpu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kpu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[hw/rtl/kpu_ctrl.sv]
// Controller state machine sequencing range check, digit extraction and emission.
`timescale 1ns / 1ps

module kpu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kpu_pkg::kpu_sts_t sts,
  output kpu_pkg::kpu_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_ERR   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Accept a new transaction only when idle
  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.bad_input) begin
          state_nxt = S_ERR;
        end else begin
          cmd.init  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // subtract the factorial until the rank drops below it
        if (sts.rank_ge) begin
          cmd.sub = 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_pos ? S_IDLE : S_DIV;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/kpu_dp.sv]
// Datapath: rank registers, subtract-based digit divider, unused-element list, output register.
`timescale 1ns / 1ps

module kpu_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  kpu_pkg::kpu_in_t  in_data,
  input  logic              out_stall,
  output logic              out_valid,
  output kpu_pkg::kpu_out_t out_data,
  input  kpu_pkg::kpu_cmd_t cmd,
  output kpu_pkg::kpu_sts_t sts
);

  localparam int NumElems = kpu_pkg::SizeCap;
  localparam int ListW    = NumElems * kpu_pkg::ElemW;

  logic [kpu_pkg::SizeW-1:0] size_r;
  logic [kpu_pkg::RankW-1:0] rank_r;
  logic [kpu_pkg::RankW-1:0] rem_r, rem_nxt;
  logic [kpu_pkg::SizeW-1:0] places_r, places_nxt;
  logic [kpu_pkg::SizeW-1:0] pick_r, pick_nxt;
  logic [ListW-1:0]          list_r, list_nxt;
  logic                      out_valid_r, out_valid_nxt;
  kpu_pkg::kpu_out_t         out_r, out_nxt;

  logic [kpu_pkg::RankW-1:0] fact_cur;
  logic [ListW-1:0]          list_up;
  logic [kpu_pkg::ElemW-1:0] chosen;

  // Range check of the captured transaction
  assign sts.bad_input = (size_r == '0) ||
                         (size_r > kpu_pkg::SizeW'(kpu_pkg::SizeCap)) ||
                         (rank_r == '0) ||
                         (rank_r > kpu_pkg::kpu_fact(size_r));

  // Factorial of the places after the current one
  assign fact_cur     = kpu_pkg::kpu_fact(places_r - kpu_pkg::SizeW'(1));
  assign sts.rank_ge  = (rem_r >= fact_cur);
  assign sts.last_pos = (places_r == kpu_pkg::SizeW'(1));
  assign sts.out_free = !out_valid_r || !out_stall;

  // Select the pick-th unused element
  assign chosen  = list_r[{pick_r, 2'b00} +: kpu_pkg::ElemW];
  assign list_up = list_r >> kpu_pkg::ElemW;

  // Working registers
  always_comb begin
    rem_nxt    = rem_r;
    places_nxt = places_r;
    pick_nxt   = pick_r;
    list_nxt   = list_r;
    if (cmd.init) begin
      rem_nxt    = rank_r - kpu_pkg::RankW'(1);
      places_nxt = size_r;
      pick_nxt   = '0;
      for (int i = 0; i < NumElems; i++) begin
        list_nxt[i*kpu_pkg::ElemW +: kpu_pkg::ElemW] = kpu_pkg::ElemW'(i + 1);
      end
    end else if (cmd.sub) begin
      rem_nxt  = rem_r - fact_cur;
      pick_nxt = pick_r + kpu_pkg::SizeW'(1);
    end else if (cmd.emit) begin
      // drop the chosen element, close the gap above it
      places_nxt = places_r - kpu_pkg::SizeW'(1);
      pick_nxt   = '0;
      for (int i = 0; i < NumElems; i++) begin
        if (kpu_pkg::SizeW'(i) >= pick_r) begin
          list_nxt[i*kpu_pkg::ElemW +: kpu_pkg::ElemW] =
            list_up[i*kpu_pkg::ElemW +: kpu_pkg::ElemW];
        end
      end
    end
  end

  // Output register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_nxt.element = chosen;
      out_nxt.last    = sts.last_pos;
      out_nxt.error   = 1'b0;
      out_valid_nxt   = 1'b1;
    end else if (cmd.emit_err) begin
      out_nxt.element = '0;
      out_nxt.last    = 1'b1;
      out_nxt.error   = 1'b1;
      out_valid_nxt   = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size_r <= in_data.set_size;
      rank_r <= in_data.rank;
    end
    rem_r    <= rem_nxt;
    places_r <= places_nxt;
    pick_r   <= pick_nxt;
    list_r   <= list_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/kpu_checker.sv]
// Port-level checker for the permutation unranker, bound to the top level.
`timescale 1ns / 1ps

module kpu_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input kpu_pkg::kpu_out_t out_data
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Refuse input in the cycle after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // Error results carry element zero and close the permutation
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.last && (out_data.element == '0))
    else $error("malformed error result");

  // Normal results carry an element within 1..SizeCap
  a_element_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.error |->
      (out_data.element != '0) &&
      (out_data.element <= kpu_pkg::ElemW'(kpu_pkg::SizeCap)))
    else $error("element out of range");

endmodule

bind kth_permutation_unrank kpu_checker u_kpu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/sv/tb_kth_permutation_unrank.sv]
// Self-checking testbench for the k-th permutation unranker: directed and random ranks.
`timescale 1ns / 1ps

module tb_kth_permutation_unrank;

  localparam int ClkHalf      = 5;
  localparam int ResetCycles  = 7;
  localparam int DrainLimit   = 20000;
  localparam int SettleCycles = 100;
  localparam int RunLimitNs   = 5_000_000;
  localparam int NoisePct     = 20;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  kpu_pkg::kpu_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  kpu_pkg::kpu_out_t out_data;

  // Permutation elements still owed by the block, oldest first
  kpu_pkg::kpu_out_t perm_expect_q[$];
  int unsigned       err_count      = 0;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;

  kth_permutation_unrank dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  function automatic longint unsigned fact_of(input int unsigned m);
    longint unsigned f;
    f = 1;
    for (int unsigned i = 2; i <= m; i++) f *= i;
    return f;
  endfunction

  // Work out the elements of the k-th permutation of 1..n, or the single error result
  function automatic void predict_unrank(input kpu_pkg::kpu_in_t t);
    int unsigned       n;
    int unsigned       pos;
    int unsigned       e;
    int unsigned       seen;
    int unsigned       chosen;
    longint unsigned   k;
    longint unsigned   rest;
    longint unsigned   f;
    longint unsigned   pick;
    logic [15:0]       used;
    kpu_pkg::kpu_out_t r;
    n = t.set_size;
    k = t.rank;
    if (n < 1 || n > kpu_pkg::SizeCap || k == 0 || k > fact_of(n)) begin
      r.element = '0;
      r.last    = 1'b1;
      r.error   = 1'b1;
      perm_expect_q.push_back(r);
      return;
    end
    rest = k - 1;
    used = '0;
    for (pos = n; pos > 0; pos--) begin
      f    = fact_of(pos - 1);
      pick = rest / f;
      rest -= pick * f;
      seen   = 0;
      chosen = 0;
      // pick the unused element whose position among the unused ones is the digit
      for (e = 1; e <= n; e++) begin
        if (!used[e-1]) begin
          if (seen == pick) begin
            chosen = e;
            break;
          end
          seen++;
        end
      end
      if (chosen != 0) used[chosen-1] = 1'b1;
      r.element = chosen[kpu_pkg::ElemW-1:0];
      r.last    = (pos == 1);
      r.error   = 1'b0;
      perm_expect_q.push_back(r);
    end
  endfunction

  // Compare each result transaction with the oldest expectation, then predict new input
  always @(posedge clk) begin : result_check
    kpu_pkg::kpu_out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (perm_expect_q.size() == 0) begin
          $error("unexpected result: element %0d last %0b error %0b",
                 out_data.element, out_data.last, out_data.error);
          err_count++;
        end else begin
          want = perm_expect_q.pop_front();
          if (out_data.element !== want.element) begin
            $error("element: expected %0d, actual %0d", want.element, out_data.element);
            err_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, out_data.last);
            err_count++;
          end
          if (out_data.error !== want.error) begin
            $error("error: expected %0b, actual %0b", want.error, out_data.error);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_unrank(in_data);
    end
  end

  // Stall the result channel at random, at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one transaction after any idle cycles and hold it until accepted
  task automatic send_item(input kpu_pkg::kpu_in_t item);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_sized(input int unsigned n, input longint unsigned k);
    kpu_pkg::kpu_in_t item;
    item.set_size = n[kpu_pkg::SizeW-1:0];
    item.rank     = k[kpu_pkg::RankW-1:0];
    send_item(item);
  endtask

  // Mostly well-formed ranks, with a share of out-of-range sizes and ranks
  function automatic kpu_pkg::kpu_in_t rand_rank_item();
    kpu_pkg::kpu_in_t item;
    int unsigned      n;
    n             = $urandom_range(1, kpu_pkg::SizeCap);
    item.set_size = n[kpu_pkg::SizeW-1:0];
    case ($urandom_range(9))
      0:       item.rank = kpu_pkg::RankW'(fact_of(n));
      1:       item.rank = kpu_pkg::RankW'(1);
      default: item.rank = kpu_pkg::RankW'($urandom_range(1, 32'(fact_of(n))));
    endcase
    if ($urandom_range(99) < NoisePct) begin
      case ($urandom_range(3))
        0: begin
          if ($urandom_range(1) == 0) item.set_size = '0;
          else item.set_size = kpu_pkg::SizeW'($urandom_range(kpu_pkg::SizeCap + 1, 15));
        end
        1: item.rank = '0;
        2: item.rank = kpu_pkg::RankW'(fact_of(n) + $urandom_range(1, 4096));
        default: begin
          item.set_size = kpu_pkg::SizeW'($urandom);
          item.rank     = kpu_pkg::RankW'($urandom);
        end
      endcase
    end
    return item;
  endfunction

  // Smallest and largest sets, every permutation of three, first and last ranks
  task automatic test_directed_valid();
    send_sized(1, 1);
    for (int unsigned k = 1; k <= 6; k++) send_sized(3, k);
    send_sized(4, 24);
    send_sized(11, fact_of(11));
    send_sized(12, 1);
    send_sized(12, fact_of(12) / 2);
    send_sized(12, fact_of(12));
  endtask

  // Size out of range, zero rank and rank above n!, with all-zero and all-one fields
  task automatic test_directed_errors();
    send_sized(0, 0);
    send_sized(0, 1);
    send_sized(13, 1);
    send_sized(15, (1 << kpu_pkg::RankW) - 1);
    send_sized(5, 0);
    send_sized(1, 2);
    send_sized(4, 25);
    send_sized(12, fact_of(12) + 1);
    send_sized(12, (1 << kpu_pkg::RankW) - 1);
  endtask

  task automatic run_random_phase(input int unsigned count, input int unsigned idle_pct,
                                  input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(rand_rank_item());
  endtask

  task automatic test_streaming();
    run_random_phase(60, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random_phase(55, 88, 0);
  endtask

  task automatic test_receiver_backpressure();
    run_random_phase(55, 0, 88);
  endtask

  task automatic test_both_idle();
    run_random_phase(60, 38, 38);
  endtask

  initial begin
    int unsigned drain_wait;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_valid();
    test_directed_errors();
    test_streaming();
    test_sender_gaps();
    test_receiver_backpressure();
    test_both_idle();

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    drain_wait = 0;
    while (perm_expect_q.size() != 0 && drain_wait < DrainLimit) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SettleCycles) @(posedge clk);
    if (perm_expect_q.size() != 0) begin
      $error("%0d expected results never arrived", perm_expect_q.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #(RunLimitNs);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
hw/rtl/kpu_pkg.sv
hw/rtl/kpu_ctrl.sv
hw/rtl/kpu_dp.sv
hw/rtl/kth_permutation_unrank.sv
hw/rtl/kpu_checker.sv
tb/sv/tb_kth_permutation_unrank.sv
